### hw/rtl/aroon_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aroon indicator package
// Shared widths, constants and the sequencer state type of the Aroon core.
// ----------------------------------------------------------------------------
package aroon_pkg;

    // Field widths.
    localparam int PRICE_W   = 32;
    localparam int PERIOD_W  = 7;
    localparam int PCT_W     = 15;
    localparam int OSC_W     = 16;

    // Default ring depth in bars.
    localparam int MAX_PERIOD_DEF = 64;

    // Period register value after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd25;

    // Percent times 256.
    localparam int SCALE = 25600;

    // Widest dividend: the largest period times the scale.
    localparam int NUM_MAX = ((1 << PERIOD_W) - 1) * SCALE;
    localparam int NUM_W   = $clog2(NUM_MAX + 1);
    localparam int BIT_W   = $clog2(NUM_W);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### hw/rtl/aroon_indicator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aroon indicator core
// Stores price bars in two ring buffers and computes Aroon-up, Aroon-down
// and the oscillator with one scan unit and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
// One bar (high, low, start flag) is taken per transfer on the input
// channel (i_in_valid / o_in_ready). The start flag begins a new series.
// Once a full window of bars has been seen, every further bar produces one
// result transfer on the output channel (o_out_valid / i_out_ready).
// Bars that give no result leave the sequencer idle, so the next bar can
// transfer at the following edge. A bar with a result runs a scan of both
// rings through their registered read port, then two restoring divisions
// on the shared divider, each after a load step, then the output step;
// the next bar can transfer once the sequencer is back in idle.
// o_in_ready is high only while the sequencer idles; a result waiting in
// the output register does not block the next bar, but a second finished
// result holds until the receiver takes the first one.
// Reset sets the period to 25 and clears the bar count and write slot;
// ring contents are not cleared. The period is written via i_cfg_we.
// ----------------------------------------------------------------------------
module aroon_indicator_core #(
    parameter int MAX_PERIOD = aroon_pkg::MAX_PERIOD_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aroon_pkg::PERIOD_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [aroon_pkg::PRICE_W-1:0]       i_high_price,
    input  logic [aroon_pkg::PRICE_W-1:0]       i_low_price,
    input  logic                                i_start_series,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [aroon_pkg::PCT_W-1:0]         o_aroon_up,
    output logic [aroon_pkg::PCT_W-1:0]         o_aroon_down,
    output logic signed [aroon_pkg::OSC_W-1:0]  o_aroon_osc
);

    localparam int PW   = aroon_pkg::PERIOD_W;
    localparam int SW   = $clog2(MAX_PERIOD);
    localparam int AW   = ((SW > PW) ? SW : PW) + 1;
    localparam int NW   = aroon_pkg::NUM_W;
    localparam int BW   = aroon_pkg::BIT_W;
    localparam int PCW  = aroon_pkg::PCT_W;
    localparam int OW   = aroon_pkg::OSC_W;
    localparam int DW   = aroon_pkg::PRICE_W;
    localparam logic [PW-1:0] MAX_P = (MAX_PERIOD > (1 << PW) - 1) ?
                                      PW'((1 << PW) - 1) : PW'(MAX_PERIOD);

    // Registers.
    aroon_pkg::t_state r_state, n_state;
    logic [PW-1:0]  r_period;
    logic [PW-1:0]  r_p;
    logic [SW-1:0]  r_write_slot;
    logic [PW-1:0]  r_bars_seen;
    logic [SW-1:0]  r_now;
    logic [SW-1:0]  r_idx;
    logic           r_issue;
    logic           r_cmp_vld;
    logic           r_cmp_last;
    logic [SW-1:0]  r_cmp_idx;
    logic [DW-1:0]  r_hi_q;
    logic [DW-1:0]  r_lo_q;
    logic [DW-1:0]  r_best_hi;
    logic [DW-1:0]  r_best_lo;
    logic [SW-1:0]  r_imax;
    logic [SW-1:0]  r_imin;
    logic           r_sel;
    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_quo;
    logic [PW-1:0]  r_rem;
    logic [BW-1:0]  r_bit;
    logic [PCW-1:0] r_up;
    logic [PCW-1:0] r_down;
    logic           r_out_valid;
    logic [PCW-1:0] r_o_up;
    logic [PCW-1:0] r_o_down;
    logic [OW-1:0]  r_o_osc;

    // Ring memories.
    logic [DW-1:0]  r_high_ring [MAX_PERIOD];
    logic [DW-1:0]  r_low_ring  [MAX_PERIOD];

    // Combinational signals.
    logic [PW-1:0]  p_eff;
    logic           in_acc;
    logic           out_free;
    logic [SW-1:0]  slot_base;
    logic [SW-1:0]  now_slot;
    logic [SW-1:0]  next_slot;
    logic [PW-1:0]  bars_cl;
    logic [PW-1:0]  next_bars;
    logic           emit;
    logic           scan_rd;
    logic           load_en;
    logic           div_en;
    logic           out_load;
    logic [SW-1:0]  best_slot;
    logic [AW-1:0]  factor_w;
    logic [PW-1:0]  factor;
    logic [PW:0]    trial;
    logic           q_bit;
    logic [PW-1:0]  n_rem;
    logic [NW-1:0]  n_quo;

    // Effective period: zero acts as one, large values clamp to the depth.
    always_comb begin
        if (r_period == '0) begin
            p_eff = PW'(1);
        end else if (r_period > MAX_P) begin
            p_eff = MAX_P;
        end else begin
            p_eff = r_period;
        end
    end

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Slot and bar count bookkeeping for an incoming bar.
    always_comb begin
        slot_base = i_start_series ? '0 : r_write_slot;
        now_slot  = (AW'(slot_base) >= AW'(p_eff)) ? '0 : slot_base;
        next_slot = (AW'(now_slot) + AW'(1) >= AW'(p_eff)) ? '0 : SW'(now_slot + SW'(1));
        if (i_start_series) begin
            bars_cl = '0;
        end else if (r_bars_seen > p_eff) begin
            bars_cl = p_eff;
        end else begin
            bars_cl = r_bars_seen;
        end
        emit      = (bars_cl >= p_eff);
        next_bars = emit ? bars_cl : PW'(bars_cl + PW'(1));
    end

    // Factor (p - age) for the selected extreme.
    always_comb begin
        best_slot = r_sel ? r_imin : r_imax;
        if (AW'(best_slot) <= AW'(r_now)) begin
            factor_w = AW'(r_p) - AW'(r_now) + AW'(best_slot);
        end else begin
            factor_w = AW'(best_slot) - AW'(r_now);
        end
        factor = factor_w[PW-1:0];
    end

    // One restoring division step.
    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        q_bit = (trial >= {1'b0, r_p});
        n_rem = q_bit ? PW'(trial - {1'b0, r_p}) : trial[PW-1:0];
        n_quo = {r_quo[NW-2:0], q_bit};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aroon_pkg::S_IDLE: begin
                if (in_acc && emit) begin
                    n_state = aroon_pkg::S_SCAN;
                end
            end
            aroon_pkg::S_SCAN: begin
                if (r_cmp_vld && r_cmp_last) begin
                    n_state = aroon_pkg::S_LOAD;
                end
            end
            aroon_pkg::S_LOAD: begin
                n_state = aroon_pkg::S_DIV;
            end
            aroon_pkg::S_DIV: begin
                if (r_bit == '0) begin
                    n_state = r_sel ? aroon_pkg::S_OUT : aroon_pkg::S_LOAD;
                end
            end
            aroon_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = aroon_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aroon_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready = 1'b0;
        scan_rd    = 1'b0;
        load_en    = 1'b0;
        div_en     = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            aroon_pkg::S_IDLE: o_in_ready = 1'b1;
            aroon_pkg::S_SCAN: scan_rd    = r_issue;
            aroon_pkg::S_LOAD: load_en    = 1'b1;
            aroon_pkg::S_DIV:  div_en     = 1'b1;
            aroon_pkg::S_OUT:  out_load   = out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // State, configuration and series bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aroon_pkg::S_IDLE;
            r_period     <= aroon_pkg::PERIOD_RESET;
            r_write_slot <= '0;
            r_bars_seen  <= '0;
            r_issue      <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_sel        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= scan_rd;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_write_slot <= next_slot;
                r_bars_seen  <= next_bars;
                r_issue      <= emit;
                r_sel        <= 1'b0;
            end else if (scan_rd && (AW'(r_idx) + AW'(1) >= AW'(r_p))) begin
                r_issue <= 1'b0;
            end
            if (div_en && (r_bit == '0)) begin
                r_sel <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Ring writes on each bar transfer.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_high_ring[now_slot] <= i_high_price;
            r_low_ring[now_slot]  <= i_low_price;
        end
    end

    // Registered ring reads for the scan.
    always_ff @(posedge i_clk) begin
        r_hi_q <= r_high_ring[r_idx];
        r_lo_q <= r_low_ring[r_idx];
    end

    // Scan address counter and extreme search; ties keep the lowest slot.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p   <= p_eff;
            r_now <= now_slot;
            r_idx <= '0;
        end else if (scan_rd) begin
            r_idx <= SW'(r_idx + SW'(1));
        end
        r_cmp_idx  <= r_idx;
        r_cmp_last <= (AW'(r_idx) + AW'(1) >= AW'(r_p));
        if (r_cmp_vld) begin
            if ((r_cmp_idx == '0) || (r_hi_q > r_best_hi)) begin
                r_best_hi <= r_hi_q;
                r_imax    <= r_cmp_idx;
            end
            if ((r_cmp_idx == '0) || (r_lo_q < r_best_lo)) begin
                r_best_lo <= r_lo_q;
                r_imin    <= r_cmp_idx;
            end
        end
    end

    // Shared divider: (p - age) * 25600 / p, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_num <= NW'(factor) * NW'(aroon_pkg::SCALE);
            r_quo <= '0;
            r_rem <= '0;
            r_bit <= BW'(NW - 1);
        end else if (div_en) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_bit <= BW'(r_bit - BW'(1));
            if (r_bit == '0) begin
                if (r_sel) begin
                    r_down <= n_quo[PCW-1:0];
                end else begin
                    r_up <= n_quo[PCW-1:0];
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_up   <= r_up;
            r_o_down <= r_down;
            r_o_osc  <= OW'(r_up) - OW'(r_down);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_aroon_up   = r_o_up;
    assign o_aroon_down = r_o_down;
    assign o_aroon_osc  = signed'(r_o_osc);

    // Assertions.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aroon_pkg::S_DIV) |-> (r_rem < r_p))
        else $error("Divider remainder reached the divisor.");

    a_cmp_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == aroon_pkg::S_SCAN))
        else $error("Compare stage active outside the scan.");

    a_extreme_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aroon_pkg::S_LOAD) |->
        ((AW'(r_imax) < AW'(r_p)) && (AW'(r_imin) < AW'(r_p))))
        else $error("Extreme slot lies outside the window.");

    a_start_counts_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_start_series) |=> (r_bars_seen == PW'(1)))
        else $error("Series start did not restart the bar count.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && (r_state == aroon_pkg::S_IDLE)))
        else $error("Finished result was not presented.");

endmodule

### test/aroon_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aroon indicator checker
// Watches the configuration port and both channels of the Aroon core, keeps
// its own copy of the price rings, bar count and period, predicts the
// result of every bar transfer that finds a full window and compares each
// output transfer against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module aroon_checker #(
    parameter int MAX_PERIOD = aroon_pkg::MAX_PERIOD_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [aroon_pkg::PERIOD_W-1:0]     i_cfg_wdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [aroon_pkg::PRICE_W-1:0]      i_high_price,
    input  logic [aroon_pkg::PRICE_W-1:0]      i_low_price,
    input  logic                               i_start_series,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [aroon_pkg::PCT_W-1:0]        i_aroon_up,
    input  logic [aroon_pkg::PCT_W-1:0]        i_aroon_down,
    input  logic [aroon_pkg::OSC_W-1:0]        i_aroon_osc,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);

    localparam int PRICE_W  = aroon_pkg::PRICE_W;
    localparam int PERIOD_W = aroon_pkg::PERIOD_W;
    localparam int PCT_W    = aroon_pkg::PCT_W;
    localparam int OSC_W    = aroon_pkg::OSC_W;
    localparam int SCALE    = aroon_pkg::SCALE;

    typedef struct {
        logic [PCT_W-1:0] up;
        logic [PCT_W-1:0] down;
        logic [OSC_W-1:0] osc;
    } t_aroon_result;

    // Model state of the core.
    logic [PRICE_W-1:0]  high_hist [MAX_PERIOD];
    logic [PRICE_W-1:0]  low_hist  [MAX_PERIOD];
    logic [PERIOD_W-1:0] period_reg;
    int unsigned         next_slot;
    int unsigned         bar_count;

    // Indicator values still owed by the core, oldest first.
    t_aroon_result       owed_results [$];

    int                  fail_count = 0;
    int                  checked    = 0;

    // A period of zero acts as one bar; anything above the ring depth is clamped.
    function automatic int unsigned window_len(logic [PERIOD_W-1:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (raw > MAX_PERIOD) begin
            return MAX_PERIOD;
        end
        return raw;
    endfunction

    // Percent times 256 from the distance between the newest slot and the extreme.
    function automatic int unsigned aroon_pct(int unsigned extreme_slot,
                                              int unsigned now_slot,
                                              int unsigned len);
        int unsigned age;
        if (extreme_slot <= now_slot) begin
            age = now_slot - extreme_slot;
        end else begin
            age = len - extreme_slot + now_slot;
        end
        return ((len - age) * SCALE) / len;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Store one bar and, once a full window has been seen, queue its result.
    task automatic predict_bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                               logic start);
        int unsigned   len;
        int unsigned   now_slot;
        int unsigned   peak;
        int unsigned   trough;
        int unsigned   up_pct;
        int unsigned   down_pct;
        bit            full_window;
        t_aroon_result res;

        len = window_len(period_reg);
        if (start) begin
            next_slot = 0;
            bar_count = 0;
        end
        // A shorter period set mid-series wraps the slot and clamps the count.
        if (next_slot >= len) begin
            next_slot = 0;
        end
        if (bar_count > len) begin
            bar_count = len;
        end

        now_slot            = next_slot;
        high_hist[now_slot] = hi;
        low_hist[now_slot]  = lo;
        full_window         = (bar_count >= len);
        if (bar_count < len) begin
            bar_count++;
        end
        next_slot = (now_slot + 1 >= len) ? 0 : now_slot + 1;

        if (full_window) begin
            // First occurrence wins on ties, so only strictly better slots move.
            peak   = 0;
            trough = 0;
            for (int i = 1; i < len; i++) begin
                if (high_hist[i] > high_hist[peak]) begin
                    peak = i;
                end
                if (low_hist[i] < low_hist[trough]) begin
                    trough = i;
                end
            end
            up_pct   = aroon_pct(peak, now_slot, len);
            down_pct = aroon_pct(trough, now_slot, len);
            res.up   = up_pct[PCT_W-1:0];
            res.down = down_pct[PCT_W-1:0];
            res.osc  = OSC_W'(up_pct - down_pct);
            owed_results.push_back(res);
        end
    endtask

    // Sample every channel at the rising edge; results before bars, since a
    // result transfer can never belong to a bar taken at the same edge.
    always @(posedge i_clk) begin : monitor
        t_aroon_result want;
        if (!i_rst_n) begin
            period_reg = aroon_pkg::PERIOD_RESET;
            next_slot  = 0;
            bar_count  = 0;
            owed_results.delete();
        end else begin
            if (i_cfg_we) begin
                period_reg = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with no bar owing one: up %0d down %0d osc %0d",
                                              i_aroon_up, i_aroon_down, $signed(i_aroon_osc)));
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (i_aroon_up !== want.up) begin
                        report_mismatch($sformatf("result %0d aroon_up %0d, expected %0d",
                                                  checked, i_aroon_up, want.up));
                    end
                    if (i_aroon_down !== want.down) begin
                        report_mismatch($sformatf("result %0d aroon_down %0d, expected %0d",
                                                  checked, i_aroon_down, want.down));
                    end
                    if (i_aroon_osc !== want.osc) begin
                        report_mismatch($sformatf("result %0d aroon_osc %0d, expected %0d",
                                                  checked, $signed(i_aroon_osc),
                                                  $signed(want.osc)));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_bar(i_high_price, i_low_price, i_start_series);
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aroon indicator core testbench
// Drives price bars in paced bursts against a stalling receiver, steps the
// period through normal, clamped and mid-series settings, and leaves all
// prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PRICE_W  = aroon_pkg::PRICE_W;
    localparam int PERIOD_W = aroon_pkg::PERIOD_W;
    localparam int PCT_W    = aroon_pkg::PCT_W;
    localparam int OSC_W    = aroon_pkg::OSC_W;

    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_BARS   = 850;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 150;
    localparam int TIMEOUT_NS    = 15_000_000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [PERIOD_W-1:0]         i_cfg_wdata;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [PRICE_W-1:0]          i_high_price;
    logic [PRICE_W-1:0]          i_low_price;
    logic                        i_start_series;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [PCT_W-1:0]            o_aroon_up;
    logic [PCT_W-1:0]            o_aroon_down;
    logic signed [OSC_W-1:0]     o_aroon_osc;

    int fail_count;
    int pending;
    int checked;

    int bars_sent     = 0;
    int period_writes = 0;
    int burst_left    = 0;
    bit pacing_on     = 1'b1;
    int hold_asks     = 0;

    aroon_indicator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_high_price   (i_high_price),
        .i_low_price    (i_low_price),
        .i_start_series (i_start_series),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_aroon_up     (o_aroon_up),
        .o_aroon_down   (o_aroon_down),
        .o_aroon_osc    (o_aroon_osc)
    );

    aroon_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_high_price   (i_high_price),
        .i_low_price    (i_low_price),
        .i_start_series (i_start_series),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_aroon_up     (o_aroon_up),
        .i_aroon_down   (o_aroon_down),
        .i_aroon_osc    (o_aroon_osc),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs or owes results forever.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("aroon_indicator_core verification failed");
        $finish;
    end

    // Receiver: switches among stall patterns, and on request holds off for
    // a long stretch so that the core backs up into its input.
    initial begin : receiver
        int holds_done;
        int mode;
        int mode_left;
        holds_done  = 0;
        mode        = 0;
        mode_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_asks) begin
                holds_done++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // Offer one bar and hold it until the transfer; then pace the next one.
    task automatic offer_bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                             logic start);
        int gap;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_high_price   <= hi;
        i_low_price    <= lo;
        i_start_series <= start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (pacing_on) begin
                gap = $urandom_range(1, 10);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Stop offering and wait until the core owes nothing and has gone idle.
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] value);
        quiesce();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        period_writes++;
    endtask

    function automatic logic [PRICE_W-1:0] extreme_price();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Stimulus: directed bars first, then random series.
    initial begin : stimulus
        logic [PRICE_W-1:0]  hi;
        logic [PRICE_W-1:0]  lo;
        logic [PRICE_W-1:0]  base;
        logic [PERIOD_W-1:0] pv;
        logic                start;
        bit                  fresh;
        bit                  hold_phase;
        int                  len;
        int                  eff;
        int                  style;
        int                  phase;
        int                  random_from;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_high_price   = '0;
        i_low_price    = '0;
        i_start_series = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Period left at its reset value: the maximum high sits in slot 1,
        // tied again in slot 5, and the newest bar carries the lowest low.
        for (int k = 0; k < 27; k++) begin
            hi = (k == 1 || k == 5) ? '1 : 32'($urandom_range(0, 32'hFFFF_FFFE));
            lo = (k == 25) ? '0 : 32'($urandom_range(1, 32'hFFFF_FFFF));
            offer_bar(hi, lo, k == 0);
        end

        // A period of zero acts as a one-bar window.
        write_period(0);
        offer_bar('0, '1, 1'b1);
        offer_bar('1, '0, 1'b0);
        offer_bar('0, '1, 1'b0);

        // Every price equal: all ties resolve to the lowest slot.
        write_period(3);
        for (int k = 0; k < 6; k++) begin
            offer_bar(32'h0001_8000, 32'h0001_8000, k == 0);
        end

        // An oversized period clamps to the ring depth; this also fills every
        // ring slot, so later mid-series changes never read stale entries.
        write_period(127);
        len = 64 + $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            offer_bar($urandom, $urandom, k == 0);
        end

        // Random series, mostly small windows, each under a fresh setting.
        phase       = 0;
        base        = $urandom;
        random_from = bars_sent;
        while (bars_sent - random_from < RANDOM_BARS) begin
            phase++;
            hold_phase = (phase % 12 == 3);
            case ($urandom_range(0, 31))
                0: pv = 0;
                1: pv = 1;
                2: pv = 127;
                3: pv = PERIOD_W'($urandom_range(65, 126));
                4: pv = 64;
                5, 6, 7, 8, 9, 10, 11: pv = PERIOD_W'($urandom_range(2, 4));
                default: pv = PERIOD_W'($urandom_range(5, 24));
            endcase
            if (hold_phase) begin
                pv = 2;
            end
            fresh = hold_phase || ($urandom_range(0, 3) != 0);
            write_period(pv);
            eff = (pv == 0) ? 1 : (pv > 64) ? 64 : int'(pv);

            if (hold_phase) begin
                len = 40;
                hold_asks++;
            end else if (fresh && $urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, eff);
            end else begin
                len = eff + $urandom_range(1, 30);
            end
            pacing_on = ($urandom_range(0, 3) != 0);
            style     = $urandom_range(0, 4);

            for (int k = 0; k < len; k++) begin
                case (style)
                    0: begin
                        hi = $urandom;
                        lo = $urandom;
                    end
                    1: begin
                        // Tiny price range, so window extremes tie often.
                        hi = $urandom_range(0, 3);
                        lo = $urandom_range(0, 3);
                    end
                    2: begin
                        // Drifting market around a moving base.
                        base = base + $urandom_range(0, 2000) - 1000;
                        hi   = base + $urandom_range(0, 500);
                        lo   = base - $urandom_range(0, 500);
                    end
                    3: begin
                        hi = extreme_price();
                        lo = extreme_price();
                    end
                    default: begin
                        lo = $urandom;
                        hi = lo + $urandom_range(0, 32'h0003_0000);
                    end
                endcase
                // A stray series start now and then breaks a running window.
                start = (fresh && k == 0) || ($urandom_range(0, 149) == 0);
                offer_bar(hi, lo, start);
            end
        end

        quiesce();
        repeat (END_CYCLES) @(negedge i_clk);

        $display("Run covered %0d bars and %0d compared results over %0d period writes,",
                 bars_sent, checked, period_writes);
        $display("with clamped periods 0 and 127, ties, price extremes and long output stalls.");
        if (fail_count == 0) begin
            $display("aroon_indicator_core verification clean");
        end else begin
            $display("aroon_indicator_core verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/aroon_pkg.sv
hw/rtl/aroon_indicator_core.sv
test/aroon_checker.sv
test/testbench.sv
